FILE: sv/postfix_expression_evaluator_unit_assert.svh
// ---------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Assertion sampled on clk_i and disabled while rst_ni is low.
`define PFE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("postfix evaluator assertion failed");

// Same, with a caller-supplied message string.
`define PFE_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

FILE: sv/pfe_pkg.sv
// ---------------------------------------------------------------------------
// Postfix evaluator package
// Sizes, symbol codes, status codes and shared types of the evaluator.
// ---------------------------------------------------------------------------
package pfe_pkg;

  // Stack and datapath sizes.
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 16;
  localparam int STAT_W      = 3;
  localparam int OUT_DATA_W  = ((OUT_W + STAT_W + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  // ASCII codes of the accepted symbols.
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_e;

  // What a stack cell loads this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ABOVE,
    CELL_BELOW
  } cell_op_e;

  // Sequencer states.
  typedef enum logic {
    FSM_IDLE,
    FSM_DIV
  } fsm_e;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

endpackage

FILE: sv/pfe_cell.sv
// ---------------------------------------------------------------------------
// Postfix evaluator stack cell
// One entry of the shifting operand stack; loads from either neighbor.
// ---------------------------------------------------------------------------
module pfe_cell
  import pfe_pkg::*;
(
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  val_t     above_i,
  input  val_t     below_i,
  output val_t     value_o
);

  val_t value_q;
  val_t value_d;

  // CELL_ABOVE takes the entry above, as on a push; CELL_BELOW the entry below.
  always_comb begin
    case (op_i)
      CELL_ABOVE: value_d = above_i;
      CELL_BELOW: value_d = below_i;
      CELL_HOLD:  value_d = value_q;
      default:    value_d = value_q;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: sv/pfe_div.sv
// ---------------------------------------------------------------------------
// Postfix evaluator divider
// Signed radix-2 restoring divider, quotient truncated toward zero.
// ---------------------------------------------------------------------------
module pfe_div
  import pfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     done_o,
  output val_t     quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic [VALUE_WIDTH:0] rem_q, rem_d;
  val_t                 quo_q, quo_d;
  val_t                 dvs_q, dvs_d;
  logic [VALUE_WIDTH:0] rem_sh;
  logic [VALUE_WIDTH:0] diff;
  logic                 a_neg, b_neg;

  assign a_neg  = req_i.dividend[VALUE_WIDTH-1];
  assign b_neg  = req_i.divisor[VALUE_WIDTH-1];
  assign rem_sh = {rem_q[VALUE_WIDTH-1:0], quo_q[VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // One quotient bit per cycle on the operand magnitudes.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(VALUE_WIDTH);
      neg_d  = a_neg ^ b_neg;
      rem_d  = '0;
      quo_d  = a_neg ? val_t'(-req_i.dividend) : req_i.dividend;
      dvs_d  = b_neg ? val_t'(-req_i.divisor) : req_i.divisor;
    end else if (busy_q) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_d = diff;
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? val_t'(-quo_q) : quo_q;

endmodule

FILE: sv/postfix_expression_evaluator_unit.sv
// ---------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression streamed one ASCII character per transaction.
// ---------------------------------------------------------------------------
// Digits push onto a 16-entry stack built as a row of shifting cells, and the
// operators + - * / combine the two top entries with 16-bit wrapping
// arithmetic. A digit, +, - or * is applied as it is taken. A division is
// handed to the radix-2 divider, which produces one quotient bit per cycle,
// and its quotient is then written back; no symbol is taken meanwhile.
// On the transaction flagged by tlast one result transaction carries the top
// of the stack and a status, and the stack and error are cleared. A new
// transaction is not taken while a result waits and cannot be drained.
module postfix_expression_evaluator_unit
  import pfe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SYM_W-1:0]      s_axis_tdata_i,  // [7:0] symbol
  input  logic                  s_axis_tlast_i,  // last_symbol
  // Result stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // [15:0] value, [18:16] status
);

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          err_q, err_d;
  logic             last_q;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_value_q, out_value_d;
  status_e          out_status_q, out_status_d;

  val_t             cell_val [STACK_DEPTH];
  cell_op_e         cell_op  [STACK_DEPTH];
  val_t             new_top;
  logic             push, pop, go_div, emit;
  logic             s_acc;
  logic             is_digit, is_op;
  val_t             lhs, rhs, alu_res, digit_val;
  div_req_t         div_req;
  logic             div_done;
  val_t             div_quot;
  logic [CNT_W-1:0] fin_cnt;
  status_e          fin_err;

  assign s_axis_tready_o = (state_q == FSM_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Symbol decode and the combinational ALU.
  assign is_digit  = (s_axis_tdata_i >= SYM_ZERO) && (s_axis_tdata_i <= SYM_NINE);
  assign is_op     = (s_axis_tdata_i == SYM_PLUS) || (s_axis_tdata_i == SYM_MINUS) ||
                     (s_axis_tdata_i == SYM_STAR) || (s_axis_tdata_i == SYM_SLASH);
  assign digit_val = val_t'(s_axis_tdata_i - SYM_ZERO);
  assign rhs       = cell_val[0];
  assign lhs       = cell_val[1];

  always_comb begin
    case (s_axis_tdata_i)
      SYM_PLUS:  alu_res = lhs + rhs;
      SYM_MINUS: alu_res = lhs - rhs;
      SYM_STAR:  alu_res = val_t'(lhs * rhs);
      default:   alu_res = lhs + rhs;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (go_div) state_d = FSM_DIV;
      FSM_DIV:  if (div_done) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // Stack control, error tracking and result formation.
  always_comb begin
    push         = 1'b0;
    pop          = 1'b0;
    go_div       = 1'b0;
    emit         = 1'b0;
    new_top      = cell_val[0];
    fin_cnt      = cnt_q;
    fin_err      = err_q;
    div_req      = '{start: 1'b0, dividend: lhs, divisor: rhs};
    case (state_q)
      FSM_IDLE: begin
        if (s_acc) begin
          if (err_q == ST_OK) begin
            if (is_digit) begin
              if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
                fin_err = ST_OVERFLOW;
              end else begin
                push    = 1'b1;
                new_top = digit_val;
                fin_cnt = cnt_q + CNT_W'(1);
              end
            end else if (!is_op) begin
              fin_err = ST_UNKNOWN;
            end else if (cnt_q < CNT_W'(2)) begin
              fin_err = ST_UNDERFLOW;
            end else if (s_axis_tdata_i == SYM_SLASH) begin
              if (rhs == '0) begin
                fin_err = ST_DIVZERO;
              end else begin
                go_div        = 1'b1;
                div_req.start = 1'b1;
              end
            end else begin
              pop     = 1'b1;
              new_top = alu_res;
              fin_cnt = cnt_q - CNT_W'(1);
            end
          end
          emit = s_axis_tlast_i && !go_div;
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          pop     = 1'b1;
          new_top = div_quot;
          fin_cnt = cnt_q - CNT_W'(1);
          emit    = last_q;
        end
      end
      default: ;
    endcase

    // The result is taken from the state after this symbol.
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    cnt_d        = fin_cnt;
    err_d        = fin_err;
    if (emit) begin
      out_valid_d = 1'b1;
      if (fin_err != ST_OK) begin
        out_status_d = fin_err;
        out_value_d  = '0;
      end else if (fin_cnt == '0) begin
        out_status_d = ST_UNDERFLOW;
        out_value_d  = '0;
      end else begin
        out_status_d = ST_OK;
        out_value_d  = OUT_W'(signed'(new_top));
      end
      cnt_d = '0;
      err_d = ST_OK;
    end
  end

  // Cell controls: a pop loads the result into the top cell.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (push) begin
        cell_op[i] = CELL_ABOVE;
      end else if (pop) begin
        cell_op[i] = (i == 0) ? CELL_ABOVE : CELL_BELOW;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end
  end

  // Row of stack cells, top of stack in cell 0.
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    val_t above, below;
    if (g == 0) begin : g_top
      assign above = new_top;
    end else begin : g_inner
      assign above = cell_val[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_upper
      assign below = cell_val[g+1];
    end
    pfe_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .above_i (above),
      .below_i (below),
      .value_o (cell_val[g])
    );
  end

  pfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      last_q <= s_axis_tlast_i;
    end
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_status_q, out_value_q});

  // Checks on the sequencer and the stack.
`include "postfix_expression_evaluator_unit_assert.svh"

  `PFE_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH))
  `PFE_ASSERT(a_no_accept_in_div, (state_q == FSM_DIV) |-> !s_axis_tready_o)
  `PFE_ASSERT_MSG(a_done_in_div, div_done |-> (state_q == FSM_DIV), "divider done outside division")
  `PFE_ASSERT_MSG(a_err_sticky, (err_q != ST_OK && !(s_acc && s_axis_tlast_i)) |=> $stable(err_q), "error changed mid-expression")

endmodule
